[design/period_timer_with_pwm_core_assert.svh]
// assertion macros for the period timer core
`ifndef PERIOD_TIMER_WITH_PWM_CORE_ASSERT_SVH
`define PERIOD_TIMER_WITH_PWM_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PTPWM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptpwm check failed");

// next-cycle implication, checked out of reset
`define PTPWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptpwm check failed");

`endif

[design/ptpwm_pkg.sv]
// shared types and constants for the period timer core
package ptpwm_pkg;

  localparam int TIMER_W     = 8;
  localparam int PRESCALE_W  = 5;
  localparam int POSTSCALE_W = 5;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 16;

  localparam logic [1:0] PRESCALE_DIV_1      = 2'd0;
  localparam logic [1:0] PRESCALE_DIV_4      = 2'd1;
  localparam logic [1:0] PRESCALE_DIV_16     = 2'd2;
  localparam logic [1:0] PRESCALE_DIV_16_ALT = 2'd3;

  localparam logic [PRESCALE_W-1:0] RATIO_1  = PRESCALE_W'(1);
  localparam logic [PRESCALE_W-1:0] RATIO_4  = PRESCALE_W'(4);
  localparam logic [PRESCALE_W-1:0] RATIO_16 = PRESCALE_W'(16);

  // result bit positions in the output tdata
  localparam int OUT_MATCH_BIT = 8;
  localparam int OUT_IRQ_BIT   = 9;
  localparam int OUT_PWM1_BIT  = 10;
  localparam int OUT_PWM2_BIT  = 11;

  typedef enum logic [2:0] {
    REG_TIMER_ENABLE      = 3'd0,
    REG_PRESCALE_SELECT   = 3'd1,
    REG_POSTSCALE_SETTING = 3'd2,
    REG_PERIOD_VALUE      = 3'd3,
    REG_PWM_ONE_ENABLE    = 3'd4,
    REG_PWM_TWO_ENABLE    = 3'd5,
    REG_DUTY_ONE          = 3'd6,
    REG_DUTY_TWO          = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic               timer_enable;
    logic [1:0]         prescale_select;
    logic [3:0]         postscale_setting;
    logic [TIMER_W-1:0] period_value;
    logic               pwm_one_enable;
    logic               pwm_two_enable;
    logic [TIMER_W-1:0] duty_one;
    logic [TIMER_W-1:0] duty_two;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_W-1:0] timer_value;
    logic               period_match;
    logic               interrupt_event;
  } tmr_res_t;

endpackage

[design/ptpwm_cfg.sv]
// configuration register file
module ptpwm_cfg import ptpwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  cfg_reg_e              wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TIMER_ENABLE:      cfg.timer_enable      <= wr_data[0];
        REG_PRESCALE_SELECT:   cfg.prescale_select   <= wr_data[1:0];
        REG_POSTSCALE_SETTING: cfg.postscale_setting <= wr_data[3:0];
        REG_PERIOD_VALUE:      cfg.period_value      <= wr_data[TIMER_W-1:0];
        REG_PWM_ONE_ENABLE:    cfg.pwm_one_enable    <= wr_data[0];
        REG_PWM_TWO_ENABLE:    cfg.pwm_two_enable    <= wr_data[0];
        REG_DUTY_ONE:          cfg.duty_one          <= wr_data[TIMER_W-1:0];
        REG_DUTY_TWO:          cfg.duty_two          <= wr_data[TIMER_W-1:0];
        default:               cfg                   <= cfg;
      endcase
    end
  end

endmodule

[design/ptpwm_timer.sv]
// prescaler, 8-bit period timer and postscaler
module ptpwm_timer import ptpwm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  cfg_t     cfg,
  output tmr_res_t res
);

  logic [PRESCALE_W-1:0]  prescale_count, prescale_count_next;
  logic [PRESCALE_W-1:0]  prescale_inc, divide_ratio;
  logic [TIMER_W-1:0]     timer_count, timer_count_next, timer_inc;
  logic [POSTSCALE_W-1:0] postscale_count, postscale_count_next;
  logic [POSTSCALE_W-1:0] post_inc, post_limit;
  logic                   advance, match, irq;

  always_comb begin
    unique case (cfg.prescale_select) inside
      PRESCALE_DIV_1:                       divide_ratio = RATIO_1;
      PRESCALE_DIV_4:                       divide_ratio = RATIO_4;
      PRESCALE_DIV_16, PRESCALE_DIV_16_ALT: divide_ratio = RATIO_16;
      default:                              divide_ratio = RATIO_16;
    endcase
  end

  always_comb begin
    prescale_inc = prescale_count + PRESCALE_W'(1);
    advance      = step && (prescale_inc >= divide_ratio);
    timer_inc    = timer_count + TIMER_W'(1);
    match        = advance && (timer_inc == cfg.period_value);
    post_inc     = postscale_count + POSTSCALE_W'(1);
    post_limit   = POSTSCALE_W'(cfg.postscale_setting) + POSTSCALE_W'(1);
    irq          = match && (post_inc >= post_limit);

    prescale_count_next  = prescale_count;
    timer_count_next     = timer_count;
    postscale_count_next = postscale_count;
    if (step) begin
      prescale_count_next = advance ? '0 : prescale_inc;
    end
    if (advance) begin
      timer_count_next = match ? '0 : timer_inc;
    end
    if (match) begin
      postscale_count_next = irq ? '0 : post_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      timer_count     <= '0;
      postscale_count <= '0;
    end else begin
      prescale_count  <= prescale_count_next;
      timer_count     <= timer_count_next;
      postscale_count <= postscale_count_next;
    end
  end

  assign res.timer_value     = timer_count_next;
  assign res.period_match    = match;
  assign res.interrupt_event = irq;

endmodule

[design/ptpwm_chan.sv]
// one pwm channel: duty latch and output level
module ptpwm_chan import ptpwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               enable,
  input  logic               match,
  input  logic [TIMER_W-1:0] timer_value,
  input  logic [TIMER_W-1:0] duty,
  output logic               level_next
);

  logic [TIMER_W-1:0] duty_latch, duty_latch_next;
  logic               level;

  always_comb begin
    duty_latch_next = duty_latch;
    level_next      = level;
    if (step && enable) begin
      if (match) begin
        duty_latch_next = duty;
        level_next      = 1'b1;
      end
      if (timer_value >= duty_latch_next) begin
        level_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_latch <= '0;
      level      <= 1'b0;
    end else begin
      duty_latch <= duty_latch_next;
      level      <= level_next;
    end
  end

endmodule

[design/period_timer_with_pwm_core.sv]
// top level of the period timer with prescaler, postscaler and two pwm channels
// each accepted tick item is registered as its result item in the output register
// throughput: one item per cycle; the output register takes a new item whenever it is
// empty or being drained in the same cycle
// reset: synchronous, clears config registers, counters, duty latches, levels and output valid
module period_timer_with_pwm_core import ptpwm_pkg::*; #(
  parameter int PWM_CHANNELS = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] tick, rest zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] timer_value, [8] period_match,
                                               // [9] interrupt_event, [10] pwm_one_level,
                                               // [11] pwm_two_level, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  tmr_res_t              res;
  logic                  in_accept, step;
  logic                  ch_one_en, ch_two_en;
  logic                  level_one_next, level_two_next;
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign step          = in_accept && s_axis_tdata[0] && cfg.timer_enable;
  assign ch_one_en     = (PWM_CHANNELS >= 1) && cfg.pwm_one_enable;
  assign ch_two_en     = (PWM_CHANNELS >= 2) && cfg.pwm_two_enable;

  ptpwm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_reg_e'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ptpwm_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .res  (res)
  );

  ptpwm_chan u_chan_one (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .enable      (ch_one_en),
    .match       (res.period_match),
    .timer_value (res.timer_value),
    .duty        (cfg.duty_one),
    .level_next  (level_one_next)
  );

  ptpwm_chan u_chan_two (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .enable      (ch_two_en),
    .match       (res.period_match),
    .timer_value (res.timer_value),
    .duty        (cfg.duty_two),
    .level_next  (level_two_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= {4'b0000, level_two_next, level_one_next,
                   res.interrupt_event, res.period_match, res.timer_value};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `include "period_timer_with_pwm_core_assert.svh"

  `PTPWM_ASSERT_NOW(a_stall_blocks_input, clk, rst,
    out_valid && !m_axis_tready, !s_axis_tready)
  `PTPWM_ASSERT_NEXT(a_accept_fills_output, clk, rst, in_accept, out_valid)
  `PTPWM_ASSERT_NEXT(a_idle_item_no_event, clk, rst, in_accept && !s_axis_tdata[0],
    !out_data[OUT_MATCH_BIT] && !out_data[OUT_IRQ_BIT])
  `PTPWM_ASSERT_NOW(a_match_clears_timer, clk, rst, out_valid && out_data[OUT_MATCH_BIT],
    out_data[TIMER_W-1:0] == '0)
  `PTPWM_ASSERT_NOW(a_irq_needs_match, clk, rst, out_valid && out_data[OUT_IRQ_BIT],
    out_data[OUT_MATCH_BIT])

endmodule
